### hdl/task_event_flag_scheduler_unit_defines.svh
// Assertion macros shared by the task event flag scheduler RTL.
`ifndef TASK_EVENT_FLAG_SCHEDULER_UNIT_DEFINES_SVH
`define TASK_EVENT_FLAG_SCHEDULER_UNIT_DEFINES_SVH

// same-cycle implication
`define TEFS_ASSERT_HOLDS(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TEFS_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/tefs_pkg.sv
// Shared types, widths and codes of the task event flag scheduler.
`default_nettype none
package tefs_pkg;

  localparam int TASK_IDX_W = 4;
  localparam int MASK_W     = 16;
  localparam int STATUS_W   = 2;
  localparam int TC_W       = 5;
  localparam int EXT_W      = 8;
  localparam int WIDE_W     = 32;

  localparam int DEF_MAX_TASKS  = 16;
  localparam int DEF_EVENT_BITS = 16;

  localparam logic [TC_W-1:0] TC_RESET = 5'd16;

  localparam logic OP_SET      = 1'b0;
  localparam logic OP_DISPATCH = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_TASK = 2'd1;
  localparam logic [STATUS_W-1:0] ST_IDLE     = 2'd2;

  localparam logic [1:0] RES_SET_OK = 2'd0;
  localparam logic [1:0] RES_BAD    = 2'd1;
  localparam logic [1:0] RES_IDLE   = 2'd2;
  localparam logic [1:0] RES_GRANT  = 2'd3;

  typedef struct packed {
    logic       load;
    logic       scan_init;
    logic       scan_rd;
    logic       scan_adv;
    logic       set_wr;
    logic       res_load;
    logic [1:0] res_sel;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic op_disp;
    logic idx_ok;
    logic n_zero;
    logic hit;
    logic last;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

### hdl/tefs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tefs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

### hdl/tefs_ctrl.sv
// Controller state machine of the task event flag scheduler.
`default_nettype none
module tefs_ctrl import tefs_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_OPER  = 3'd1;
  localparam logic [2:0] S_SETWR = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_RES   = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_stall = !(rst_n && (state_r == S_IDLE));

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_OPER;
        end
      end
      S_OPER: begin
        if (!sts.op_disp) begin
          if (sts.idx_ok) begin
            state_nxt = S_SETWR;
          end else begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = RES_BAD;
            state_nxt    = S_RES;
          end
        end else if (sts.n_zero) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_IDLE;
          state_nxt    = S_RES;
        end else begin
          cmd.scan_init = 1'b1;
          state_nxt     = S_SCAN;
        end
      end
      S_SETWR: begin
        cmd.set_wr   = 1'b1;
        cmd.res_load = 1'b1;
        cmd.res_sel  = RES_SET_OK;
        state_nxt    = S_RES;
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.hit) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_GRANT;
          state_nxt    = S_RES;
        end else if (sts.last) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_IDLE;
          state_nxt    = S_RES;
        end else begin
          cmd.scan_adv = 1'b1;
        end
      end
      S_RES: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

### hdl/tefs_dpath.sv
// Datapath of the task event flag scheduler: word store, scan counters, result registers.
`default_nettype none
module tefs_dpath import tefs_pkg::*; #(
  parameter int MAX_TASKS  = DEF_MAX_TASKS,
  parameter int EVENT_BITS = DEF_EVENT_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire cmd_t                  cmd,
  output sts_t                       sts,
  input  wire logic                  in_opcode,
  input  wire logic [TASK_IDX_W-1:0] in_task_index,
  input  wire logic [MASK_W-1:0]     in_event_mask,
  input  wire logic                  cfg_wr_en,
  input  wire logic [TC_W-1:0]       cfg_wr_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic      [STATUS_W-1:0]   out_status,
  output logic      [TASK_IDX_W-1:0] out_granted_task,
  output logic      [MASK_W-1:0]     out_granted_events
);

  localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int NW = $clog2(MAX_TASKS + 1);

  logic                  op_r;
  logic [TASK_IDX_W-1:0] idx_r;
  logic [MASK_W-1:0]     mask_r;
  logic [TC_W-1:0]       task_count_r;
  logic [NW-1:0]         rd_idx_r;
  logic [NW-1:0]         ck_idx_r;
  logic [MAX_TASKS-1:0]  valid_r;
  logic [MAX_TASKS-1:0]  valid_nxt;

  logic [STATUS_W-1:0]   res_status_r;
  logic [TASK_IDX_W-1:0] res_task_r;
  logic [MASK_W-1:0]     res_events_r;
  logic                  out_valid_r;
  logic [STATUS_W-1:0]   out_status_r;
  logic [TASK_IDX_W-1:0] out_task_r;
  logic [MASK_W-1:0]     out_events_r;

  logic [EXT_W-1:0]      idx_ext;
  logic [EXT_W-1:0]      rd_ext;
  logic [EXT_W-1:0]      ck_ext;
  logic [EXT_W-1:0]      tc_ext;
  logic [EXT_W-1:0]      lim_ext;
  logic [EXT_W-1:0]      n_ext;
  logic [AW-1:0]         idx_a;
  logic [AW-1:0]         rd_a;
  logic [AW-1:0]         ck_a;
  logic [AW-1:0]         raddr;
  logic [WIDE_W-1:0]     mask_wide;
  logic [EVENT_BITS-1:0] mask_e;
  logic [EVENT_BITS-1:0] rd_data;
  logic [EVENT_BITS-1:0] set_word;
  logic [EVENT_BITS-1:0] scan_word;
  logic [WIDE_W-1:0]     scan_wide;
  logic                  out_free;

  assign idx_ext = EXT_W'(idx_r);
  assign rd_ext  = EXT_W'(rd_idx_r);
  assign ck_ext  = EXT_W'(ck_idx_r);
  assign tc_ext  = EXT_W'(task_count_r);
  assign lim_ext = EXT_W'(MAX_TASKS);
  assign n_ext   = (tc_ext > lim_ext) ? lim_ext : tc_ext;

  assign idx_a = idx_ext[AW-1:0];
  assign rd_a  = rd_ext[AW-1:0];
  assign ck_a  = ck_ext[AW-1:0];
  assign raddr = cmd.scan_rd ? rd_a : (op_r == OP_DISPATCH) ? '0 : idx_a;

  assign mask_wide = WIDE_W'(mask_r);
  assign mask_e    = mask_wide[EVENT_BITS-1:0];
  assign set_word  = valid_r[idx_a] ? rd_data : '0;
  assign scan_word = valid_r[ck_a] ? rd_data : '0;
  assign scan_wide = WIDE_W'(scan_word);

  tefs_ram #(
    .WIDTH (EVENT_BITS),
    .DEPTH (MAX_TASKS)
  ) u_words (
    .clk   (clk),
    .we    (cmd.set_wr),
    .waddr (idx_a),
    .wdata (set_word | mask_e),
    .raddr (raddr),
    .rdata (rd_data)
  );

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    sts.op_disp  = (op_r == OP_DISPATCH);
    sts.idx_ok   = (idx_ext < n_ext);
    sts.n_zero   = (n_ext == '0);
    sts.hit      = |scan_word;
    sts.last     = ((ck_ext + EXT_W'(1)) == n_ext);
    sts.out_free = out_free;
  end

  always_comb begin
    valid_nxt = valid_r;
    if (cmd.set_wr) begin
      valid_nxt[idx_a] = 1'b1;
    end
    if (cmd.res_load && (cmd.res_sel == RES_GRANT)) begin
      valid_nxt[ck_a] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      task_count_r <= TC_RESET;
      valid_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        task_count_r <= cfg_wr_data;
      end
      valid_r <= valid_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_opcode;
      idx_r  <= in_task_index;
      mask_r <= in_event_mask;
    end
    if (cmd.scan_init) begin
      rd_idx_r <= NW'(1);
      ck_idx_r <= '0;
    end else if (cmd.scan_adv) begin
      rd_idx_r <= rd_idx_r + NW'(1);
      ck_idx_r <= rd_idx_r;
    end
    if (cmd.res_load) begin
      unique case (cmd.res_sel)
        RES_SET_OK: begin
          res_status_r <= ST_OK;
          res_task_r   <= '0;
          res_events_r <= '0;
        end
        RES_BAD: begin
          res_status_r <= ST_BAD_TASK;
          res_task_r   <= '0;
          res_events_r <= '0;
        end
        RES_IDLE: begin
          res_status_r <= ST_IDLE;
          res_task_r   <= '0;
          res_events_r <= '0;
        end
        RES_GRANT: begin
          res_status_r <= ST_OK;
          res_task_r   <= ck_ext[TASK_IDX_W-1:0];
          res_events_r <= scan_wide[MASK_W-1:0];
        end
      endcase
    end
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_task_r   <= res_task_r;
      out_events_r <= res_events_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_granted_task   = out_task_r;
  assign out_granted_events = out_events_r;

endmodule
`default_nettype wire

### hdl/task_event_flag_scheduler_unit.sv
// Top level of the task event flag scheduler: controller, datapath and checks.
// Usage:
//   Input channel in_valid/in_stall carries one transaction: in_opcode selects a
//   set (OR in_event_mask into task in_task_index) or a dispatch (take and clear
//   the lowest-numbered task word that is nonzero).
//   Result channel out_valid/out_stall returns one transaction per input:
//   out_status, out_granted_task and out_granted_events.
//   cfg_wr_en/cfg_wr_data write the task count; write it only while idle.
//   Steps: a set passes the operand, write and result states before out_valid;
//   a rejected set and a dispatch with task count zero go from the operand state
//   straight to the result state; any other dispatch scans the task words from
//   word 0 up, at most min(task_count, MAX_TASKS) words. The scan reads one word
//   per cycle from the single-read word RAM, which sets the dispatch time.
//   One transaction is in work at a time; a new one is taken once the previous
//   result sits in the output register.
//   Reset clears all task words (per-task valid bits), sets the task count to 16
//   and empties the output register. While out_stall is high the result holds
//   and a finished next result waits inside the block.
`default_nettype none
`include "task_event_flag_scheduler_unit_defines.svh"
module task_event_flag_scheduler_unit import tefs_pkg::*; #(
  parameter int MAX_TASKS  = DEF_MAX_TASKS,
  parameter int EVENT_BITS = DEF_EVENT_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  in_opcode,
  input  wire logic [TASK_IDX_W-1:0] in_task_index,
  input  wire logic [MASK_W-1:0]     in_event_mask,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic      [STATUS_W-1:0]   out_status,
  output logic      [TASK_IDX_W-1:0] out_granted_task,
  output logic      [MASK_W-1:0]     out_granted_events,
  input  wire logic                  cfg_wr_en,
  input  wire logic [TC_W-1:0]       cfg_wr_data
);

  cmd_t cmd;
  sts_t sts;

  tefs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  tefs_dpath #(
    .MAX_TASKS  (MAX_TASKS),
    .EVENT_BITS (EVENT_BITS)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_opcode          (in_opcode),
    .in_task_index      (in_task_index),
    .in_event_mask      (in_event_mask),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_granted_task   (out_granted_task),
    .out_granted_events (out_granted_events)
  );

  `TEFS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, rst_n && in_valid && !in_stall, in_stall, "input taken while a transaction is in work")
  `TEFS_ASSERT_HOLDS(a_status_code, clk, rst_n, out_valid, (out_status == ST_OK) || (out_status == ST_BAD_TASK) || (out_status == ST_IDLE), "undefined status code")
  `TEFS_ASSERT_HOLDS(a_no_grant_on_fail, clk, rst_n, out_valid && (out_status != ST_OK), (out_granted_task == '0) && (out_granted_events == '0), "grant fields set on failed transaction")

endmodule
`default_nettype wire
